>>> design/cdat_pkg.sv
// Shared types and constants for the countdown alarm timer.
`default_nettype none
package cdat_pkg;

    localparam logic [7:0] TICKS_RESET = 8'd6;
    localparam logic [5:0] TOP_SM      = 6'd59;
    localparam logic [3:0] TOP_TENTH   = 4'd9;
    localparam int         QUEUE_DEPTH = 2;

    // Classified tick, passed from the front end to the timer core
    typedef struct packed {
        logic toggle;    // rising button edge
        logic enc_step;  // rising encoder CLK edge
        logic enc_down;  // step direction, 1 = down
    } tick_cmd_t;

endpackage
`default_nettype wire

>>> design/countdown_alarm_timer_encoder_set.sv
// Countdown alarm timer set by a rotary encoder, valid/ready tick stream in, one result per tick out.
`default_nettype none
// Each input beat is one timer tick carrying the sampled button and encoder
// levels; each tick yields exactly one result beat with the time as it stood
// before the tick plus the LED and run state after it. The block takes one
// tick per clock cycle when the result side keeps up: the front end detects
// edges and pushes into a two-entry queue, and the timer core retires one
// queue entry per cycle into a single output register. An accepted input
// beat is held in a queue entry and then in the output register before
// result valid rises. ticks_per_tenth is written through cfg_wr_en and
// cfg_wr_data and resets to 6; write it only while no tick is in flight.
module countdown_alarm_timer_encoder_set
    import cdat_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_button_level,
    input  wire logic       s_encoder_clk,
    input  wire logic       s_encoder_dt,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [5:0]      m_minutes_out,
    output logic [5:0]      m_seconds_out,
    output logic [3:0]      m_tenths_out,
    output logic            m_alarm_on,
    output logic            m_running
);

    logic      q_full;
    logic      q_push;
    tick_cmd_t push_cmd;
    logic      q_pop;
    logic      q_not_empty;
    tick_cmd_t head_cmd;

    cdat_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .s_encoder_clk  (s_encoder_clk),
        .s_encoder_dt   (s_encoder_dt),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    cdat_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    cdat_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_not_empty   (q_not_empty),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_minutes_out (m_minutes_out),
        .m_seconds_out (m_seconds_out),
        .m_tenths_out  (m_tenths_out),
        .m_alarm_on    (m_alarm_on),
        .m_running     (m_running)
    );

endmodule
`default_nettype wire

>>> design/cdat_front.sv
// Front end: accepts tick beats and turns input levels into edge events.
`default_nettype none
module cdat_front
    import cdat_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire logic      s_button_level,
    input  wire logic      s_encoder_clk,
    input  wire logic      s_encoder_dt,
    input  wire logic      q_full,
    output logic           q_push,
    output tick_cmd_t      q_cmd
);

    logic last_button_reg, last_button_next;
    logic last_clk_reg, last_clk_next;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.toggle   = s_button_level && !last_button_reg;
        q_cmd.enc_step = s_encoder_clk && !last_clk_reg;
        q_cmd.enc_down = s_encoder_dt;
        last_button_next = last_button_reg;
        last_clk_next    = last_clk_reg;
        if (q_push) begin
            last_button_next = s_button_level;
            last_clk_next    = s_encoder_clk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_button_reg <= 1'b0;
            last_clk_reg    <= 1'b0;
        end else begin
            last_button_reg <= last_button_next;
            last_clk_reg    <= last_clk_next;
        end
    end

endmodule
`default_nettype wire

>>> design/cdat_queue.sv
// Two-entry queue of classified ticks between front end and timer core.
`default_nettype none
module cdat_queue
    import cdat_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire tick_cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output tick_cmd_t      head_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    tick_cmd_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]          count_reg, count_next;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> design/cdat_back.sv
// Timer core: applies classified ticks to the countdown state and registers the result.
`default_nettype none
module cdat_back
    import cdat_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       q_not_empty,
    input  wire tick_cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [5:0]      m_minutes_out,
    output logic [5:0]      m_seconds_out,
    output logic [3:0]      m_tenths_out,
    output logic            m_alarm_on,
    output logic            m_running
);

    logic [7:0] ticks_per_tenth_reg;
    logic       stopped_reg, stopped_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [3:0] tenths_reg, tenths_next;
    logic [5:0] seconds_reg, seconds_next;
    logic [5:0] minutes_reg, minutes_next;
    logic       led_reg, led_next;
    logic       m_valid_reg, m_valid_next;
    logic [5:0] out_min_reg;
    logic [5:0] out_sec_reg;
    logic [3:0] out_ten_reg;
    logic       out_alarm_reg;
    logic       out_run_reg;

    logic [5:0] sec_enc, min_enc;
    logic [7:0] tick_inc;

    // advance when the output slot is free or being drained
    assign q_pop = q_not_empty && (!m_valid_reg || m_ready);

    always_comb begin
        stopped_next = stopped_reg ^ q_cmd.toggle;

        sec_enc = seconds_reg;
        min_enc = minutes_reg;
        if (q_cmd.enc_step) begin
            if (!q_cmd.enc_down) begin
                if (seconds_reg >= TOP_SM) begin
                    sec_enc = '0;
                    min_enc = (minutes_reg >= TOP_SM) ? 6'd0 : minutes_reg + 6'd1;
                end else begin
                    sec_enc = seconds_reg + 6'd1;
                end
            end else begin
                if (seconds_reg == '0) begin
                    sec_enc = TOP_SM;
                    min_enc = (minutes_reg == '0) ? TOP_SM : minutes_reg - 6'd1;
                end else begin
                    sec_enc = seconds_reg - 6'd1;
                end
            end
        end

        tick_inc        = tick_count_reg + 8'd1;
        tick_count_next = tick_count_reg;
        tenths_next     = tenths_reg;
        seconds_next    = sec_enc;
        minutes_next    = min_enc;
        led_next        = led_reg;

        if (!stopped_next) begin
            led_next        = 1'b0;
            tick_count_next = tick_inc;
            if (tenths_reg == '0 && sec_enc == '0 && min_enc == '0) begin
                led_next = 1'b1;
            end else if (tick_inc >= ticks_per_tenth_reg) begin
                tick_count_next = '0;
                if (tenths_reg == '0) begin
                    tenths_next = TOP_TENTH;
                    if (sec_enc == '0) begin
                        seconds_next = TOP_SM;
                        minutes_next = min_enc - 6'd1;
                    end else begin
                        seconds_next = sec_enc - 6'd1;
                    end
                end else begin
                    tenths_next = tenths_reg - 4'd1;
                end
            end
        end

        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_tenth_reg <= TICKS_RESET;
            stopped_reg         <= 1'b0;
            tick_count_reg      <= '0;
            tenths_reg          <= '0;
            seconds_reg         <= '0;
            minutes_reg         <= '0;
            led_reg             <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ticks_per_tenth_reg <= cfg_wr_data;
            end
            if (q_pop) begin
                stopped_reg    <= stopped_next;
                tick_count_reg <= tick_count_next;
                tenths_reg     <= tenths_next;
                seconds_reg    <= seconds_next;
                minutes_reg    <= minutes_next;
                led_reg        <= led_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // result shows the time as it stood before this beat
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_min_reg   <= minutes_reg;
            out_sec_reg   <= seconds_reg;
            out_ten_reg   <= tenths_reg;
            out_alarm_reg <= led_next;
            out_run_reg   <= !stopped_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_minutes_out = out_min_reg;
    assign m_seconds_out = out_sec_reg;
    assign m_tenths_out  = out_ten_reg;
    assign m_alarm_on    = out_alarm_reg;
    assign m_running     = out_run_reg;

endmodule
`default_nettype wire
